FILE: src/vertex_transform_normalize_top_defines.svh
// Assertion macros shared by the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_NORMALIZE_TOP_DEFINES_SVH
`define VERTEX_TRANSFORM_NORMALIZE_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define VTN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vertex transform assertion failed");

// Implication whose consequent is checked in the clock cycle after the antecedent.
`define VTN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vertex transform assertion failed");

`endif

FILE: src/vtn_pkg.sv
// Package with the widths, register indexes and stage types of the vertex transform.
package vtn_pkg;

    localparam int POS_W   = 32;
    localparam int COL_W   = 48;
    localparam int NRM_W   = 16;
    localparam int CLIP_W  = 40;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int PROD_W  = 48;
    localparam int ACC_W   = 50;
    localparam int SQ_W    = 31;
    localparam int LEN_W   = 32;
    localparam int REM_W   = 64;
    localparam int TRM_W   = 50;
    localparam int WORK_W  = 68;
    localparam int Q_W     = 15;
    localparam int NSTEP   = 15;
    localparam int LATENCY = 20;

    localparam logic [IDX_W-1:0] CFG_COL0  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_COL1  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_COL2  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_COL3  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CAM_X = 3'd4;
    localparam logic [IDX_W-1:0] CFG_CAM_Y = 3'd5;
    localparam logic [IDX_W-1:0] CFG_CAM_Z = 3'd6;

    typedef struct packed {
        logic                     vld;
        logic                     zero;
        logic [2:0]               neg;
        logic [3:0][CLIP_W-1:0]   clip;
        logic [COL_W-1:0]         color;
        logic [2:0][POS_W-1:0]    world;
    } t_side;

endpackage

FILE: src/vertex_transform_normalize_top.sv
// Pipelined camera-relative 4x4 vertex transform with normal normalization.
//
// The block accepts one vertex per clock and never asserts o_busy. Each result
// appears on the output ports for one cycle with o_valid once its transaction
// has passed through the pipeline, which is made up of three stages
// of subtract, multiply and sum for the matrix product, one rounding stage,
// fifteen stages that each resolve one bit of the unit normal by a
// shift-and-add compare, and the output register. Configuration writes take
// effect at once and must be issued only while no transaction is in flight.
`include "vertex_transform_normalize_top_defines.svh"

module vertex_transform_normalize_top
    import vtn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [COL_W-1:0]         i_color_in,
    input  logic signed [NRM_W-1:0]  i_norm_in_x,
    input  logic signed [NRM_W-1:0]  i_norm_in_y,
    input  logic signed [NRM_W-1:0]  i_norm_in_z,
    output logic                     o_valid,
    output logic signed [CLIP_W-1:0] o_clip_x,
    output logic signed [CLIP_W-1:0] o_clip_y,
    output logic signed [CLIP_W-1:0] o_clip_z,
    output logic signed [CLIP_W-1:0] o_clip_w,
    output logic [COL_W-1:0]         o_color_out,
    output logic signed [NRM_W-1:0]  o_norm_out_x,
    output logic signed [NRM_W-1:0]  o_norm_out_y,
    output logic signed [NRM_W-1:0]  o_norm_out_z,
    output logic signed [POS_W-1:0]  o_world_x,
    output logic signed [POS_W-1:0]  o_world_y,
    output logic signed [POS_W-1:0]  o_world_z
);

    logic [3:0][CFG_W-1:0]      r_col;
    logic [2:0][POS_W-1:0]      r_cam;

    logic                       r1_vld;
    logic signed [POS_W-1:0]    r1_rel [0:2];
    logic signed [NRM_W-1:0]    r1_nrm [0:2];
    logic [COL_W-1:0]           r1_color;
    logic [2:0][POS_W-1:0]      r1_world;
    logic signed [POS_W-1:0]    n1_rel [0:2];
    logic [2:0][POS_W-1:0]      w_pos;
    logic [2:0][NRM_W-1:0]      w_nrm;

    logic                       r2_vld;
    logic signed [PROD_W-1:0]   r2_prod [0:3][0:2];
    logic [SQ_W-1:0]            r2_sq [0:2];
    logic [2:0]                 r2_neg;
    logic [COL_W-1:0]           r2_color;
    logic [2:0][POS_W-1:0]      r2_world;

    logic                       r3_vld;
    logic signed [ACC_W-1:0]    r3_acc [0:3];
    logic [LEN_W-1:0]           r3_len;
    logic [SQ_W-1:0]            r3_sq [0:2];
    logic [2:0]                 r3_neg;
    logic [COL_W-1:0]           r3_color;
    logic [2:0][POS_W-1:0]      r3_world;

    t_side                      r_side [0:NSTEP];
    logic [LEN_W-1:0]           r_len  [0:NSTEP];
    logic signed [REM_W-1:0]    r_rem  [0:NSTEP][0:2];
    logic [TRM_W-1:0]           r_trm  [0:NSTEP][0:2];
    logic [Q_W-1:0]             r_q    [0:NSTEP][0:2];

    logic                       r_o_zero;

    assign o_busy = 1'b0;
    assign w_pos  = {i_pos_z, i_pos_y, i_pos_x};
    assign w_nrm  = {i_norm_in_z, i_norm_in_y, i_norm_in_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= 64'h0000_0000_0000_1000;
            r_col[1] <= 64'h0000_0000_1000_0000;
            r_col[2] <= 64'h0000_1000_0000_0000;
            r_col[3] <= 64'h1000_0000_0000_0000;
            r_cam    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COL0:  r_col[0] <= i_cfg_data;
                CFG_COL1:  r_col[1] <= i_cfg_data;
                CFG_COL2:  r_col[2] <= i_cfg_data;
                CFG_COL3:  r_col[3] <= i_cfg_data;
                CFG_CAM_X: r_cam[0] <= i_cfg_data[POS_W-1:0];
                CFG_CAM_Y: r_cam[1] <= i_cfg_data[POS_W-1:0];
                CFG_CAM_Z: r_cam[2] <= i_cfg_data[POS_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        logic [POS_W:0] d;
        for (int i = 0; i < 3; i++) begin
            d = {w_pos[i][POS_W-1], w_pos[i]} - {r_cam[i][POS_W-1], r_cam[i]};
            if (d[POS_W] != d[POS_W-1]) begin
                n1_rel[i] = d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            end else begin
                n1_rel[i] = d[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_start;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        for (int i = 0; i < 3; i++) begin
            r1_rel[i] <= n1_rel[i];
            r1_nrm[i] <= w_nrm[i];
        end
        r1_color <= i_color_in;
        r1_world <= w_pos;

        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                r2_prod[r][c] <= PROD_W'(signed'(r_col[c][16*r +: 16]) * r1_rel[c]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            r2_sq[i]  <= SQ_W'(r1_nrm[i] * r1_nrm[i]);
            r2_neg[i] <= r1_nrm[i][NRM_W-1];
        end
        r2_color <= r1_color;
        r2_world <= r1_world;

        for (int r = 0; r < 4; r++) begin
            r3_acc[r] <= ACC_W'(r2_prod[r][0]) + ACC_W'(r2_prod[r][1]) + ACC_W'(r2_prod[r][2])
                       + ACC_W'(signed'({r_col[3][16*r +: 16], 8'h00}));
        end
        r3_len   <= LEN_W'(r2_sq[0]) + LEN_W'(r2_sq[1]) + LEN_W'(r2_sq[2]);
        r3_sq    <= r2_sq;
        r3_neg   <= r2_neg;
        r3_color <= r2_color;
        r3_world <= r2_world;
    end

    always_ff @(posedge i_clk) begin
        logic signed [ACC_W-1:0] s;
        if (!i_rst_n) begin
            r_side[0].vld <= 1'b0;
        end else begin
            r_side[0].vld <= r3_vld;
        end
        for (int r = 0; r < 4; r++) begin
            s = r3_acc[r] + ACC_W'(2048);
            r_side[0].clip[r] <= {{2{s[ACC_W-1]}}, s[ACC_W-1:12]};
        end
        r_side[0].zero  <= (r3_len == '0);
        r_side[0].neg   <= r3_neg;
        r_side[0].color <= r3_color;
        r_side[0].world <= r3_world;
        r_len[0]        <= r3_len;
        for (int i = 0; i < 3; i++) begin
            r_rem[0][i] <= REM_W'({r3_sq[i], 30'b0});
            r_trm[0][i] <= '0;
            r_q[0][i]   <= '0;
        end
    end

    for (genvar k = 1; k <= NSTEP; k++) begin : g_step
        localparam int B = NSTEP - k;

        always_ff @(posedge i_clk) begin
            logic [WORK_W-1:0] lw;
            logic [WORK_W-1:0] tw;
            logic [WORK_W-1:0] need;
            logic [WORK_W-1:0] add;
            if (!i_rst_n) begin
                r_side[k].vld <= 1'b0;
            end else begin
                r_side[k].vld <= r_side[k-1].vld;
            end
            r_side[k].zero  <= r_side[k-1].zero;
            r_side[k].neg   <= r_side[k-1].neg;
            r_side[k].clip  <= r_side[k-1].clip;
            r_side[k].color <= r_side[k-1].color;
            r_side[k].world <= r_side[k-1].world;
            r_len[k]        <= r_len[k-1];
            lw = WORK_W'(r_len[k-1]);
            for (int i = 0; i < 3; i++) begin
                tw   = WORK_W'(r_trm[k-1][i]);
                add  = (tw << (B + 2)) + (lw << (2 * B + 2));
                need = add + lw - (tw << 1) - (lw << (B + 2));
                if (!r_q[k-1][i][Q_W-1]
                    && $signed({1'b0, need}) <= $signed({{(WORK_W-REM_W+1){r_rem[k-1][i][REM_W-1]}},
                                                         r_rem[k-1][i]})) begin
                    r_q[k][i]   <= r_q[k-1][i] | (Q_W'(1) << B);
                    r_rem[k][i] <= r_rem[k-1][i] - REM_W'(add);
                    r_trm[k][i] <= r_trm[k-1][i] + TRM_W'(lw << (B + 1));
                end else begin
                    r_q[k][i]   <= r_q[k-1][i];
                    r_rem[k][i] <= r_rem[k-1][i];
                    r_trm[k][i] <= r_trm[k-1][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NRM_W-1:0] nv [0:2];
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_side[NSTEP].vld;
        end
        for (int i = 0; i < 3; i++) begin
            if (r_side[NSTEP].zero) begin
                nv[i] = '0;
            end else if (r_side[NSTEP].neg[i]) begin
                nv[i] = NRM_W'(0) - NRM_W'(r_q[NSTEP][i]);
            end else begin
                nv[i] = NRM_W'(r_q[NSTEP][i]);
            end
        end
        o_norm_out_x <= nv[0];
        o_norm_out_y <= nv[1];
        o_norm_out_z <= nv[2];
        o_clip_x     <= r_side[NSTEP].clip[0];
        o_clip_y     <= r_side[NSTEP].clip[1];
        o_clip_z     <= r_side[NSTEP].clip[2];
        o_clip_w     <= r_side[NSTEP].clip[3];
        o_color_out  <= r_side[NSTEP].color;
        o_world_x    <= r_side[NSTEP].world[0];
        o_world_y    <= r_side[NSTEP].world[1];
        o_world_z    <= r_side[NSTEP].world[2];
        r_o_zero     <= r_side[NSTEP].zero;
    end

    `VTN_ASSERT_IMP(a_latency, i_start && !o_busy, ##LATENCY o_valid)
    `VTN_ASSERT_IMP(a_norm_range, o_valid, o_norm_out_x <= 16'sd16384 && o_norm_out_x >= -16'sd16384)
    `VTN_ASSERT_IMP(a_zero_norm, o_valid && r_o_zero, o_norm_out_x == '0 && o_norm_out_y == '0 && o_norm_out_z == '0)
    `VTN_ASSERT_NEXT(a_no_spurious, !r_side[NSTEP].vld, !o_valid)

endmodule
